FILE: sv/smpq_pkg.sv
package smpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PRIO_BITS_DEF   = 8;
    localparam int HANDLE_BITS     = 4;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_DEL_MIN  = 2'd2,
        OP_PICK_MIN = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

FILE: sv/stable_min_priority_queue.sv
// channel   direction  handshake                    payload
// command   in         start high, busy low         i_op, i_handle, i_prio
// result    out        o_result_strobe, one cycle   o_status, o_out_valid,
//                                                   o_out_handle, o_out_prio
//
// Each operation is accepted in S_IDLE, then executed in S_EXEC, in which all
// slots compare against the key in parallel and the sorted table shifts.
// The result strobe comes in the cycle after execute; busy is low then, so a
// new command may be accepted in that same cycle. Sync reset empties the queue.
// The receiver cannot stall; results are never held.
module stable_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_op,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [PRIO_BITS-1:0]   i_prio,
    output logic                   o_result_strobe,
    output logic [1:0]             o_status,
    output logic                   o_out_valid,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [PRIO_BITS-1:0]   o_out_prio
);

    t_cmd cmd;

    smpq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_cmd           (cmd)
    );

    smpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PRIO_BITS   (PRIO_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_handle     (i_handle),
        .i_prio       (i_prio),
        .o_status     (o_status),
        .o_out_valid  (o_out_valid),
        .o_out_handle (o_out_handle),
        .o_out_prio   (o_out_prio)
    );

endmodule

FILE: sv/smpq_ctrl.sv
module smpq_ctrl
    import smpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_result_strobe,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;
    logic   n_strobe;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign busy            = (r_state == S_EXEC);
    assign o_result_strobe = r_strobe;
    assign o_cmd.load      = start && (r_state == S_IDLE);
    assign o_cmd.exec      = (r_state == S_EXEC);

endmodule

FILE: sv/smpq_dp.sv
module smpq_dp
    import smpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [1:0]             i_op,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [PRIO_BITS-1:0]   i_prio,
    output logic [1:0]             o_status,
    output logic                   o_out_valid,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [PRIO_BITS-1:0]   o_out_prio
);

    localparam int D      = QUEUE_DEPTH;
    localparam int LEVELS = $clog2(D);

    t_op                    r_op;
    logic [HANDLE_BITS-1:0] r_key_handle;
    logic [PRIO_BITS-1:0]   r_key_prio;

    logic [D-1:0]           r_valid;
    logic [HANDLE_BITS-1:0] r_handle [D];
    logic [PRIO_BITS-1:0]   r_prio   [D];

    logic [1:0]             r_status;
    logic                   r_out_valid;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [PRIO_BITS-1:0]   r_out_prio;

    logic [D-1:0] le;
    logic [D-1:0] hit;
    logic [D-1:0] pre [LEVELS+1];
    logic         empty;
    logic         full;
    logic         found;
    logic         do_ins;
    logic         do_rem;
    t_status      n_status;
    logic         n_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= t_op'(i_op);
            r_key_handle <= i_handle;
            r_key_prio   <= i_prio;
        end
    end

    always_comb begin
        for (int i = 0; i < D; i++) begin
            le[i] = r_valid[i] && (r_prio[i] <= r_key_prio);
            if (r_op == OP_DELETE) begin
                hit[i] = r_valid[i] && (r_handle[i] == r_key_handle);
            end else begin
                hit[i] = (i == 0) && r_valid[i];
            end
        end
    end

    // parallel prefix OR: pre[LEVELS][i] is set at and after the first hit
    always_comb begin
        pre[0] = hit;
        for (int k = 0; k < LEVELS; k++) begin
            pre[k+1] = pre[k];
            for (int i = 0; i < D; i++) begin
                if (i >= (1 << k)) begin
                    pre[k+1][i] = pre[k][i] | pre[k][i-(1<<k)];
                end
            end
        end
    end

    always_comb begin
        empty       = !r_valid[0];
        full        = r_valid[D-1];
        found       = pre[LEVELS][D-1];
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        n_out_valid = 1'b0;
        n_status    = ST_OK;
        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    do_rem = 1'b1;
                end
            end
            OP_DEL_MIN: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_rem      = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            OP_PICK_MIN: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (n_out_valid) begin
                r_out_handle <= r_handle[0];
                r_out_prio   <= r_prio[0];
            end else begin
                r_out_handle <= '0;
                r_out_prio   <= '0;
            end
        end
    end

    for (genvar g = 0; g < D; g++) begin : g_slot
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == D - 1) ? g : g + 1;
        localparam bit FIRST = (g == 0);
        localparam bit LAST  = (g == D - 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_cmd.exec) begin
                if (do_ins) begin
                    r_valid[g] <= r_valid[g] | (FIRST ? 1'b1 : r_valid[PREV]);
                end else if (do_rem) begin
                    r_valid[g] <= LAST ? 1'b0 : r_valid[NEXT];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                if (do_ins) begin
                    if (!FIRST && !le[PREV]) begin
                        r_handle[g] <= r_handle[PREV];
                        r_prio[g]   <= r_prio[PREV];
                    end else if (!le[g]) begin
                        r_handle[g] <= r_key_handle;
                        r_prio[g]   <= r_key_prio;
                    end
                end else if (do_rem && !LAST && pre[LEVELS][g]) begin
                    r_handle[g] <= r_handle[NEXT];
                    r_prio[g]   <= r_prio[NEXT];
                end
            end
        end
    end

    assign o_status     = r_status;
    assign o_out_valid  = r_out_valid;
    assign o_out_handle = r_out_handle;
    assign o_out_prio   = r_out_prio;

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int PBITS       = PRIO_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        t_status                status;
        logic                   valid;
        logic [HANDLE_BITS-1:0] handle;
        logic [PBITS-1:0]       prio;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   start    = 1'b0;
    logic                   busy;
    logic [1:0]             i_op     = OP_PICK_MIN;
    logic [HANDLE_BITS-1:0] i_handle = '0;
    logic [PBITS-1:0]       i_prio   = '0;
    logic                   o_result_strobe;
    logic [1:0]             o_status;
    logic                   o_out_valid;
    logic [HANDLE_BITS-1:0] o_out_handle;
    logic [PBITS-1:0]       o_out_prio;

    logic [HANDLE_BITS-1:0] sorted_handle [DEPTH];
    logic [PBITS-1:0]       sorted_prio   [DEPTH];
    int                     sorted_count = 0;
    t_result                pending_results [$];
    int                     error_count = 0;
    int                     idle_pct = 0;
    int                     cycle_count = 0;

    stable_min_priority_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_handle        (i_handle),
        .i_prio          (i_prio),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_out_valid     (o_out_valid),
        .o_out_handle    (o_out_handle),
        .o_out_prio      (o_out_prio)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void remove_entry(int pos);
        for (int i = pos; i + 1 < sorted_count; i++) begin
            sorted_handle[i] = sorted_handle[i + 1];
            sorted_prio[i]   = sorted_prio[i + 1];
        end
        sorted_count--;
    endfunction

    function automatic t_result apply_queue_op(t_op op, logic [HANDLE_BITS-1:0] h,
                                               logic [PBITS-1:0] p);
        t_result r;
        int      pos;
        r = '{status: ST_OK, valid: 1'b0, handle: '0, prio: '0};
        case (op)
            OP_INSERT: begin
                if (sorted_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < sorted_count && sorted_prio[pos] <= p) pos++;
                    for (int i = sorted_count; i > pos; i--) begin
                        sorted_handle[i] = sorted_handle[i - 1];
                        sorted_prio[i]   = sorted_prio[i - 1];
                    end
                    sorted_handle[pos] = h;
                    sorted_prio[pos]   = p;
                    sorted_count++;
                end
            end
            OP_DELETE: begin
                if (sorted_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < sorted_count && sorted_handle[pos] != h) pos++;
                    if (pos >= sorted_count) r.status = ST_NOT_FOUND;
                    else remove_entry(pos);
                end
            end
            default: begin
                if (sorted_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.valid  = 1'b1;
                    r.handle = sorted_handle[0];
                    r.prio   = sorted_prio[0];
                    if (op == OP_DEL_MIN) remove_entry(0);
                end
            end
        endcase
        return r;
    endfunction

    // start stays high into the next beat unless an idle gap follows
    task automatic send_op(t_op op, logic [HANDLE_BITS-1:0] h, logic [PBITS-1:0] p);
        start    <= 1'b1;
        i_op     <= op;
        i_handle <= h;
        i_prio   <= p;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_queue_op(op, h, p));
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_op(OP_DELETE, 4'hF, 8'hFF);
        send_op(OP_DEL_MIN, 4'h0, 8'h00);
        send_op(OP_PICK_MIN, 4'h0, 8'h00);
    endtask

    task automatic test_fill_to_full();
        logic [PBITS-1:0] prios [DEPTH];
        prios = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd128, 8'd0, 8'd255, 8'd7,
                  8'd1, 8'd254, 8'd7, 8'd0, 8'd128, 8'd64, 8'd7, 8'd3};
        for (int i = 0; i < DEPTH; i++) send_op(OP_INSERT, HANDLE_BITS'(i % 8), prios[i]);
        send_op(OP_INSERT, 4'hF, 8'd0);
    endtask

    task automatic test_lookup_and_remove();
        send_op(OP_PICK_MIN, 4'h0, 8'h00);
        send_op(OP_DELETE, 4'hF, 8'h00);
        send_op(OP_DELETE, 4'h3, 8'h00);
        send_op(OP_DEL_MIN, 4'h0, 8'h00);
        send_op(OP_DEL_MIN, 4'h0, 8'h00);
    endtask

    // alternating fill/drain bias so both the full and empty ends get hit
    task automatic test_random_ops(int n);
        t_op                    op;
        logic [HANDLE_BITS-1:0] h;
        logic [PBITS-1:0]       p;
        int                     insert_pct;
        for (int k = 0; k < n; k++) begin
            insert_pct = ((k / 40) % 2) ? 25 : 75;
            if ($urandom_range(0, 99) < insert_pct) begin
                op = OP_INSERT;
            end else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_DELETE;
                    1:       op = OP_DEL_MIN;
                    default: op = OP_PICK_MIN;
                endcase
            end
            if (op == OP_DELETE && sorted_count > 0 && $urandom_range(0, 3) != 0)
                h = sorted_handle[$urandom_range(0, sorted_count - 1)];
            else
                h = HANDLE_BITS'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:       p = PBITS'($urandom_range(0, 3));
                1:       p = $urandom_range(0, 1) ? '1 : '0;
                default: p = PBITS'($urandom_range(0, 255));
            endcase
            send_op(op, h, p);
        end
    endtask

    task automatic test_idle_phases();
        int phase_idle [4];
        phase_idle = '{0, 57, 0, 30};
        foreach (phase_idle[i]) begin
            idle_pct = phase_idle[i];
            test_random_ops(300);
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("o_status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_out_valid !== want.valid) begin
                    $error("o_out_valid: expected %0d, got %0d", want.valid, o_out_valid);
                    error_count++;
                end
                if (o_out_handle !== want.handle) begin
                    $error("o_out_handle: expected %0d, got %0d", want.handle, o_out_handle);
                    error_count++;
                end
                if (o_out_prio !== want.prio) begin
                    $error("o_out_prio: expected %0d, got %0d", want.prio, o_out_prio);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_queue();
        test_fill_to_full();
        test_lookup_and_remove();
        wait_drained();
        test_idle_phases();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
